/* hw/rtl/olse_pkg.sv */
// Shared types and constants for the ordered list shift engine.
package olse_pkg;

  // Capacity of the list and derived widths
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 5;
  localparam int POS_W  = 5;
  localparam int WORD_W = 32;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // Request codes
  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_INS   = 3'd2,
    REQ_ERASE = 3'd3,
    REQ_FILL  = 3'd4,
    REQ_TRUNC = 3'd5
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;    // apply the request on the ports this cycle
  } olse_cmd_t;

endpackage

/* hw/rtl/olse_ctrl.sv */
// Controller: accepts a request word and sequences the result strobe.
module olse_ctrl
  import olse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output olse_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept = start_i && !busy_q;

  // State and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RESP;
            busy_q  <= 1'b1;
            done_q  <= 1'b1;
          end
        end
        S_RESP: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign cmd_o.exec = accept;

  // Every result follows exactly one accepted word
  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(accept)) else $error("result without accepted word");
  a_no_accept_in_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |-> !accept) else $error("word accepted during result");
  a_resp_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");

endmodule

/* hw/rtl/olse_datapath.sv */
// Datapath: cell chain with parallel shift, entry count and result view.
module olse_datapath
  import olse_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  olse_cmd_t                cmd_i,
  input  logic [2:0]               req_type_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic [1:0]               status_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     is_empty_o,
  output logic signed [WORD_W-1:0] front_word_o,
  output logic signed [WORD_W-1:0] back_word_o
);

  logic [WORD_W-1:0] cells_q [DEPTH];
  logic [WORD_W-1:0] cells_d [DEPTH];
  logic [CNT_W-1:0]  held_q, held_d;
  status_e           status_q, status_d;
  logic [CNT_W-1:0]  ins_pos;
  logic [CNT_W-1:0]  held_m1;
  logic [IDX_W-1:0]  back_idx;
  logic              not_full;

  assign not_full = held_q < DEPTH_C;
  // insert at or past the tail appends
  assign ins_pos  = (position_i >= held_q) ? held_q : position_i;

  // Next state of count, status and every cell
  always_comb begin
    held_d   = held_q;
    status_d = ST_DONE;
    for (int i = 0; i < DEPTH; i++) begin
      cells_d[i] = cells_q[i];
    end
    unique case (req_type_i)
      REQ_PUSH: begin
        if (!not_full) begin
          status_d = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == held_q) cells_d[i] = value_i;
          end
          held_d = held_q + 1'b1;
        end
      end
      REQ_POP: begin
        if (held_q == '0) status_d = ST_NONE;
        else held_d = held_q - 1'b1;
      end
      REQ_INS: begin
        if (!not_full) begin
          status_d = ST_FULL;
        end else begin
          // each cell takes the word, its lower neighbor, or keeps
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) == ins_pos) begin
              cells_d[i] = value_i;
            end else if (i > 0 && CNT_W'(i) > ins_pos && CNT_W'(i) <= held_q) begin
              cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
            end
          end
          held_d = held_q + 1'b1;
        end
      end
      REQ_ERASE: begin
        if (position_i >= held_q) begin
          status_d = ST_NONE;
        end else begin
          // each cell at or above the hole takes its upper neighbor
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (CNT_W'(i) >= position_i && CNT_W'(i + 1) < held_q) begin
              cells_d[i] = cells_q[i + 1];
            end
          end
          held_d = held_q - 1'b1;
        end
      end
      REQ_FILL: begin
        if (position_i > DEPTH_C) begin
          status_d = ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (CNT_W'(i) < position_i) cells_d[i] = value_i;
          end
          if (held_q < position_i) held_d = position_i;
        end
      end
      REQ_TRUNC: begin
        if (position_i < held_q) held_d = position_i;
      end
      default: begin
        status_d = ST_NONE;
      end
    endcase
  end

  // Cell storage: payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        cells_q[i] <= cells_d[i];
      end
    end
  end

  // Count and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      status_q <= ST_DONE;
    end else if (cmd_i.exec) begin
      held_q   <= held_d;
      status_q <= status_d;
    end
  end

  // Result view of the list
  assign held_m1      = held_q - 1'b1;
  assign back_idx     = held_m1[IDX_W-1:0];
  assign status_o     = status_q;
  assign count_o      = held_q;
  assign is_empty_o   = (held_q == '0);
  assign front_word_o = (held_q == '0) ? '0 : cells_q[0];
  assign back_word_o  = (held_q == '0) ? '0 : cells_q[back_idx];

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= DEPTH_C) else $error("count above capacity");
  a_reject_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (status_q == ST_DONE) || (held_q == $past(held_q)))
    else $error("rejected word changed the count");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && req_type_i == REQ_PUSH && not_full)
      |=> (held_q == CNT_W'($past(held_q) + 1'b1)) && (status_q == ST_DONE))
    else $error("push did not grow the list");

endmodule

/* hw/rtl/ordered_list_shift_engine_unit.sv */
// Top level of the ordered list shift engine: controller plus cell datapath.
//
// Usage:
//   A request word (req_type_i, position_i, value_i) is taken at a rising
//   edge where start_i is high and busy_o is low. Codes: push, pop, insert,
//   erase, fill first n, truncate to n. Insert and erase shift every cell from
//   the position up to the tail of the chain in the same cycle.
//   The result word (status_o, count_o, is_empty_o, front_word_o,
//   back_word_o) is shown for exactly one cycle with done_o high, in the
//   cycle right after the request was taken. busy_o is high in that cycle.
// Request spacing:
//   No new word is taken in the controller's result cycle, while busy_o
//   is high.
// Reset:
//   rst_ni clears the entry count, status and controller; cell contents are
//   not cleared and are never shown until written.
// Receiver:
//   The receiver cannot stall; each result must be captured in its strobe
//   cycle.
module ordered_list_shift_engine_unit
  import olse_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [2:0]               req_type_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     is_empty_o,
  output logic signed [WORD_W-1:0] front_word_o,
  output logic signed [WORD_W-1:0] back_word_o
);

  olse_cmd_t cmd;

  // Request sequencing
  olse_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  // Cell chain and result view
  olse_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .status_o     (status_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o),
    .front_word_o (front_word_o),
    .back_word_o  (back_word_o)
  );

endmodule
